/* hw/rtl/streaming_top_k_select_core_assert.svh */
// Assertion macros shared by the top-k selector RTL.
`ifndef STREAMING_TOP_K_SELECT_CORE_ASSERT_SVH
`define STREAMING_TOP_K_SELECT_CORE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define TK_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define TK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hw/rtl/stks_pkg.sv */
// Shared types and helpers for the top-k selector.
`default_nettype none
package stks_pkg;
    localparam int ScoreBits = 32;
    localparam int RankBits = 2;
    localparam int IndexOutBits = 18;

    typedef struct packed {
        logic [ScoreBits-1:0] score;
        logic last;
    } stks_in_t;

    typedef struct packed {
        logic [IndexOutBits-1:0] index;
        logic [RankBits-1:0] rank;
        logic final_res;
    } stks_out_t;

    // Unsigned key whose order is numeric float order; both zeros map alike.
    function automatic logic [ScoreBits-1:0] order_key(input logic [ScoreBits-1:0] bits);
        logic [ScoreBits-1:0] key;
        if (bits[ScoreBits-2:0] == '0)
        begin
            key = {1'b1, {(ScoreBits-1){1'b0}}};
        end
        else if (bits[ScoreBits-1])
        begin
            key = ~bits;
        end
        else
        begin
            key = bits | {1'b1, {(ScoreBits-1){1'b0}}};
        end
        return key;
    endfunction
endpackage
`default_nettype wire

/* hw/rtl/stks_front.sv */
// Front part: sorted insertion of scores, snapshots the list on the last item.
`default_nettype none
`include "streaming_top_k_select_core_assert.svh"
module stks_front import stks_pkg::*; #(
    parameter int MAX_TOP = 4,
    parameter int INDEX_BITS = 18
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire stks_in_t in_item,
    input  wire logic [2:0] top_count,
    input  wire logic snap_ready,
    output logic full,
    output logic snap_valid,
    output logic [MAX_TOP*INDEX_BITS-1:0] snap_indices,
    output logic [$clog2(MAX_TOP+1)-1:0] snap_count
);
    localparam int CntBits = $clog2(MAX_TOP+1);
    localparam logic [INDEX_BITS:0] PosLimit = {1'b1, {INDEX_BITS{1'b0}}};

    logic [ScoreBits-1:0] key_reg [MAX_TOP];
    logic [ScoreBits-1:0] key_next [MAX_TOP];
    logic [INDEX_BITS-1:0] idx_reg [MAX_TOP];
    logic [INDEX_BITS-1:0] idx_next [MAX_TOP];
    logic [CntBits-1:0] filled_reg, filled_next;
    logic [INDEX_BITS:0] pos_reg, pos_next;
    logic snap_valid_reg, snap_valid_next;
    logic [MAX_TOP*INDEX_BITS-1:0] snap_idx_reg, snap_idx_next;
    logic [CntBits-1:0] snap_cnt_reg, snap_cnt_next;
    logic [MAX_TOP-1:0] beats;
    logic [ScoreBits-1:0] new_key;
    logic in_range, accept;
    logic [CntBits-1:0] want, n_new;

    assign full = snap_valid_reg && !snap_ready;
    assign accept = push && !full;
    assign new_key = order_key(in_item.score);
    assign in_range = pos_reg < PosLimit;

    // Per-slot compare: new key beats this slot, or slot empty.
    always_comb
    begin
        for (int j = 0; j < MAX_TOP; j++)
        begin
            beats[j] = (CntBits'(j) >= filled_reg) || (new_key > key_reg[j]);
        end
    end

    // Shift-insert into the sorted row.
    always_comb
    begin
        for (int j = 0; j < MAX_TOP; j++)
        begin
            key_next[j] = key_reg[j];
            idx_next[j] = idx_reg[j];
            if (beats[j])
            begin
                if (j == 0 || !beats[(j == 0) ? 0 : j-1])
                begin
                    key_next[j] = new_key;
                    idx_next[j] = pos_reg[INDEX_BITS-1:0];
                end
                else
                begin
                    key_next[j] = key_reg[(j == 0) ? 0 : j-1];
                    idx_next[j] = idx_reg[(j == 0) ? 0 : j-1];
                end
            end
        end
    end

    // Count clamp and snapshot.
    always_comb
    begin
        if (top_count == 3'd0)
            want = CntBits'(1);
        else if (32'(top_count) > MAX_TOP)
            want = CntBits'(MAX_TOP);
        else
            want = CntBits'(top_count);
        n_new = filled_reg;
        if (in_range && filled_reg < CntBits'(MAX_TOP))
            n_new = filled_reg + CntBits'(1);
        filled_next = filled_reg;
        pos_next = pos_reg;
        snap_valid_next = snap_valid_reg && !snap_ready;
        snap_idx_next = snap_idx_reg;
        snap_cnt_next = snap_cnt_reg;
        if (accept)
        begin
            if (in_range)
            begin
                filled_next = n_new;
                pos_next = pos_reg + 1'b1;
            end
            if (in_item.last)
            begin
                filled_next = '0;
                pos_next = '0;
                snap_cnt_next = (n_new < want) ? n_new : want;
                snap_valid_next = (n_new != '0);
                for (int j = 0; j < MAX_TOP; j++)
                begin
                    snap_idx_next[j*INDEX_BITS +: INDEX_BITS] =
                        in_range ? idx_next[j] : idx_reg[j];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg <= '0;
            pos_reg <= '0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            filled_reg <= filled_next;
            pos_reg <= pos_next;
            snap_valid_reg <= snap_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_range)
        begin
            for (int j = 0; j < MAX_TOP; j++)
            begin
                key_reg[j] <= key_next[j];
                idx_reg[j] <= idx_next[j];
            end
        end
        snap_idx_reg <= snap_idx_next;
        snap_cnt_reg <= snap_cnt_next;
    end

    assign snap_valid = snap_valid_reg;
    assign snap_indices = snap_idx_reg;
    assign snap_count = snap_cnt_reg;

    `TK_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, filled_reg <= CntBits'(MAX_TOP))
    `TK_ASSERT_IMP(a_snap_count, clk, rst_n, snap_valid_reg,
        snap_cnt_reg != '0 && snap_cnt_reg <= CntBits'(MAX_TOP))
    `TK_ASSERT_NEXT(a_last_clears, clk, rst_n, accept && in_item.last,
        filled_reg == '0 && pos_reg == '0)
endmodule
`default_nettype wire

/* hw/rtl/stks_back.sv */
// Back part: walks a snapshot best first and emits one result item per index.
`default_nettype none
`include "streaming_top_k_select_core_assert.svh"
module stks_back import stks_pkg::*; #(
    parameter int MAX_TOP = 4,
    parameter int INDEX_BITS = 18
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic snap_valid,
    input  wire logic [MAX_TOP*INDEX_BITS-1:0] snap_indices,
    input  wire logic [$clog2(MAX_TOP+1)-1:0] snap_count,
    output logic snap_ready,
    output logic empty,
    input  wire logic pop,
    output stks_out_t out_item
);
    localparam int CntBits = $clog2(MAX_TOP+1);
    localparam int SelBits = (MAX_TOP > 1) ? $clog2(MAX_TOP) : 1;

    logic busy_reg, busy_next;
    logic [MAX_TOP*INDEX_BITS-1:0] list_reg, list_next;
    logic [CntBits-1:0] cnt_reg, cnt_next, k_reg, k_next;
    logic last_one, take;
    logic [INDEX_BITS-1:0] cur_idx;

    assign last_one = (k_reg + CntBits'(1)) == cnt_reg;
    assign take = busy_reg && pop;
    // Load a new list when idle or as the last entry leaves.
    assign snap_ready = !busy_reg || (take && last_one);
    assign cur_idx = list_reg[k_reg[SelBits-1:0]*INDEX_BITS +: INDEX_BITS];

    always_comb
    begin
        busy_next = busy_reg;
        list_next = list_reg;
        cnt_next = cnt_reg;
        k_next = k_reg;
        if (take)
        begin
            k_next = k_reg + CntBits'(1);
            if (last_one)
                busy_next = 1'b0;
        end
        if (snap_ready && snap_valid)
        begin
            busy_next = 1'b1;
            list_next = snap_indices;
            cnt_next = snap_count;
            k_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            k_reg <= k_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        list_reg <= list_next;
    end

    assign empty = !busy_reg;
    assign out_item.index = IndexOutBits'(cur_idx);
    assign out_item.rank = k_reg[RankBits-1:0];
    assign out_item.final_res = last_one;

    `TK_ASSERT_IMP(a_k_bound, clk, rst_n, busy_reg, k_reg < cnt_reg)
    `TK_ASSERT_NEXT(a_done_idle, clk, rst_n, take && last_one && !snap_valid, empty)
    `TK_ASSERT_NEXT(a_load_starts, clk, rst_n, snap_ready && snap_valid,
        busy_reg && k_reg == '0)
endmodule
`default_nettype wire

/* hw/rtl/streaming_top_k_select_core.sv */
// Top level of the streaming top-k selector.
// Usage:
//  Input queue side: push/full with in_item (score bits, last). One score per
//  cycle while full is low; the position in the vector is the index.
//  Result queue side: empty/pop with out_item (index, rank, final_res).
//  Configuration: cfg_we/cfg_data write top_count (0 acts as 1, above
//  MAX_TOP acts as MAX_TOP); write only while idle.
//  Throughput: one item per cycle while full is low, set by the parallel
//  compare of the new score against MAX_TOP kept entries. On the last item
//  the list is copied to a one-entry snapshot queue; the back end loads it
//  into its list register once idle or as its last entry leaves, then
//  gives one result per cycle while the receiver pops.
//  Input stalls (full) only when a snapshot waits and the back end is still
//  draining an earlier list, e.g. when the receiver does not pop.
//  Reset clears counts and pending results, so the list reads as empty; top_count goes to 4.
`default_nettype none
module streaming_top_k_select_core import stks_pkg::*; #(
    parameter int MAX_TOP = 4,
    parameter int INDEX_BITS = 18
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    output logic full,
    input  wire stks_in_t in_item,
    output logic empty,
    input  wire logic pop,
    output stks_out_t out_item,
    input  wire logic cfg_we,
    input  wire logic [2:0] cfg_data
);
    localparam int CntBits = $clog2(MAX_TOP+1);

    logic [2:0] top_count_reg;
    logic snap_valid, snap_ready;
    logic [MAX_TOP*INDEX_BITS-1:0] snap_indices;
    logic [CntBits-1:0] snap_count;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            top_count_reg <= 3'd4;
        else if (cfg_we)
            top_count_reg <= cfg_data;
    end

    stks_front #(.MAX_TOP(MAX_TOP), .INDEX_BITS(INDEX_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .in_item(in_item),
        .top_count(top_count_reg), .snap_ready(snap_ready), .full(full),
        .snap_valid(snap_valid), .snap_indices(snap_indices), .snap_count(snap_count)
    );

    stks_back #(.MAX_TOP(MAX_TOP), .INDEX_BITS(INDEX_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .snap_valid(snap_valid), .snap_indices(snap_indices),
        .snap_count(snap_count), .snap_ready(snap_ready), .empty(empty), .pop(pop),
        .out_item(out_item)
    );
endmodule
`default_nettype wire
